FILE: rtl/hpmbc_pkg.sv
// ----------------------------------------------------------------------------
// hpmbc_pkg
// Types and constants for the homography pixel map with border check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpmbc_pkg;

    // Field and datapath widths.
    localparam int COORD_W = 9;
    localparam int COEF_W  = 48;
    localparam int OUT_W   = 24;
    localparam int PROD_W  = 58;   // 48-bit signed times 10-bit signed
    localparam int SUM_W   = 60;   // two products plus an offset
    localparam int QUO_W   = 23;   // quotient magnitude bits below saturation
    localparam int SHIFT_W = 15;   // quotient overflow shift (23 - 8)
    localparam int FRAC_W  = 8;    // output fraction bits
    localparam int NUM_REGS = 8;
    localparam int IDX_W   = 3;

    // Border margin in whole pixels.
    localparam int MARGIN = 5;

    // One in Q16.32.
    localparam logic signed [SUM_W-1:0] ONE_Q32 = SUM_W'(64'sh1_0000_0000);

    // Saturation limits of the Q16.8 output.
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_COEF_X_COL = 3'd0,
        REG_COEF_X_ROW = 3'd1,
        REG_OFFSET_X   = 3'd2,
        REG_COEF_Y_COL = 3'd3,
        REG_COEF_Y_ROW = 3'd4,
        REG_OFFSET_Y   = 3'd5,
        REG_COEF_W_COL = 3'd6,
        REG_COEF_W_ROW = 3'd7
    } t_reg_idx;

    // Reset value of the scaling coefficients (1.0 in Q16.32).
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'h1_0000_0000);

    // Input request.
    typedef struct packed {
        logic [COORD_W-1:0] view_col;
        logic [COORD_W-1:0] view_row;
    } t_in_req;

    // Output request.
    typedef struct packed {
        logic [COORD_W-1:0]      echo_col;
        logic [COORD_W-1:0]      echo_row;
        logic signed [OUT_W-1:0] source_x;
        logic signed [OUT_W-1:0] source_y;
        logic                    outlier;
    } t_out_req;

    // State of one item in the divider pipeline.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               dpos;
        logic               outl;
        logic               negx;
        logic               negy;
        logic               ovfx;
        logic               ovfy;
        logic [SUM_W-1:0]   den;
        logic [SUM_W-1:0]   remx;
        logic [SUM_W-1:0]   remy;
        logic [QUO_W-1:0]   lowx;
        logic [QUO_W-1:0]   lowy;
        logic [QUO_W-1:0]   qx;
        logic [QUO_W-1:0]   qy;
    } t_div_stage;

endpackage

`default_nettype wire

FILE: rtl/homography_pixel_map_bound_check.sv
// ----------------------------------------------------------------------------
// homography_pixel_map_bound_check
// Maps a bird's-eye-view pixel through a homography to source image
// coordinates in Q16.8 and flags points near or beyond the border, or with a non-positive denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with the view column and row.
//   Results leave on o_out_valid / i_out_ready: the echoed coordinates, the
//   saturated source x and y in signed Q16.8, and the outlier flag.
//   Coefficients are written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   while no request is in flight.
//   Requests pass through registered stages in order: products, sums and
//   border products, the compare, then the divider with one quotient bit
//   per stage for x and y in parallel, and the output register.
//   Throughput is one request per cycle unless stalled; every stage is a register.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the identity homography.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module homography_pixel_map_bound_check #(
    parameter int IMAGE_COLS = 640,
    parameter int IMAGE_ROWS = 480
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  hpmbc_pkg::t_in_req                 i_in_req,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output hpmbc_pkg::t_out_req                o_out_req,
    input  wire                                i_cfg_wr_en,
    input  wire [hpmbc_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire [hpmbc_pkg::COEF_W-1:0]        i_cfg_data
);

    localparam int SW   = hpmbc_pkg::SUM_W;
    localparam int PW   = hpmbc_pkg::PROD_W;
    localparam int QW   = hpmbc_pkg::QUO_W;
    localparam int HIW  = $clog2((IMAGE_COLS > IMAGE_ROWS ? IMAGE_COLS : IMAGE_ROWS) + 1);
    localparam int KW   = SW + HIW + 1;
    localparam int FW   = SW + 3;
    localparam int OW   = SW + hpmbc_pkg::SHIFT_W;
    localparam logic [HIW-1:0] HI_X = HIW'(IMAGE_COLS - hpmbc_pkg::MARGIN);
    localparam logic [HIW-1:0] HI_Y = HIW'(IMAGE_ROWS - hpmbc_pkg::MARGIN);

    // Coefficient registers.
    logic [hpmbc_pkg::COEF_W-1:0] r_coef [hpmbc_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpmbc_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[hpmbc_pkg::REG_COEF_X_COL] <= hpmbc_pkg::COEF_ONE;
            r_coef[hpmbc_pkg::REG_COEF_Y_ROW] <= hpmbc_pkg::COEF_ONE;
        end else if (i_cfg_wr_en) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Pipeline advance: everything holds while a result waits at the output.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: six products.
    logic r1_vld;
    logic [hpmbc_pkg::COORD_W-1:0] r1_col, r1_row;
    logic signed [PW-1:0] r1_pxc, r1_pxr, r1_pyc, r1_pyr, r1_pwc, r1_pwr;
    logic signed [hpmbc_pkg::COORD_W:0] s_c, s_r;

    assign s_c = $signed({1'b0, i_in_req.view_col});
    assign s_r = $signed({1'b0, i_in_req.view_row});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_col <= i_in_req.view_col;
            r1_row <= i_in_req.view_row;
            r1_pxc <= $signed(r_coef[hpmbc_pkg::REG_COEF_X_COL]) * s_c;
            r1_pxr <= $signed(r_coef[hpmbc_pkg::REG_COEF_X_ROW]) * s_r;
            r1_pyc <= $signed(r_coef[hpmbc_pkg::REG_COEF_Y_COL]) * s_c;
            r1_pyr <= $signed(r_coef[hpmbc_pkg::REG_COEF_Y_ROW]) * s_r;
            r1_pwc <= $signed(r_coef[hpmbc_pkg::REG_COEF_W_COL]) * s_c;
            r1_pwr <= $signed(r_coef[hpmbc_pkg::REG_COEF_W_ROW]) * s_r;
        end
    end

    // Stage 2: numerators and denominator.
    logic r2_vld;
    logic [hpmbc_pkg::COORD_W-1:0] r2_col, r2_row;
    logic signed [SW-1:0] r2_nx, r2_ny, r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_nx  <= SW'(r1_pxc) + SW'(r1_pxr)
                      + SW'($signed(r_coef[hpmbc_pkg::REG_OFFSET_X]));
            r2_ny  <= SW'(r1_pyc) + SW'(r1_pyr)
                      + SW'($signed(r_coef[hpmbc_pkg::REG_OFFSET_Y]));
            r2_den <= SW'(r1_pwc) + SW'(r1_pwr) + hpmbc_pkg::ONE_Q32;
        end
    end

    // Stage 3: magnitudes, signs and border limits scaled by the denominator.
    logic r3_vld;
    logic [hpmbc_pkg::COORD_W-1:0] r3_col, r3_row;
    logic signed [SW-1:0] r3_nx, r3_ny, r3_den;
    logic [SW-1:0] r3_magx, r3_magy;
    logic signed [FW-1:0] r3_d5;
    logic signed [KW-1:0] r3_kx, r3_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_col  <= r2_col;
            r3_row  <= r2_row;
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_den  <= r2_den;
            r3_magx <= r2_nx[SW-1] ? SW'(-r2_nx) : SW'(r2_nx);
            r3_magy <= r2_ny[SW-1] ? SW'(-r2_ny) : SW'(r2_ny);
            r3_d5   <= FW'(r2_den) * $signed(FW'(hpmbc_pkg::MARGIN));
            r3_kx   <= KW'(r2_den) * $signed({1'b0, HI_X});
            r3_ky   <= KW'(r2_den) * $signed({1'b0, HI_Y});
        end
    end

    // Stage 4: border and overflow compares, divider setup.
    localparam int DS = QW;
    logic                     r_vld [DS+1];
    hpmbc_pkg::t_div_stage    r_st  [DS+1];
    logic s4_dpos, s4_outl;

    assign s4_dpos = r3_den > 0;
    assign s4_outl = !s4_dpos
                     || FW'(r3_nx) < r3_d5 || KW'(r3_nx) > r3_kx
                     || FW'(r3_ny) < r3_d5 || KW'(r3_ny) > r3_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0].col  <= r3_col;
            r_st[0].row  <= r3_row;
            r_st[0].dpos <= s4_dpos;
            r_st[0].outl <= s4_outl;
            r_st[0].negx <= r3_nx[SW-1];
            r_st[0].negy <= r3_ny[SW-1];
            r_st[0].ovfx <= OW'(r3_magx) >= {SW'(r3_den), hpmbc_pkg::SHIFT_W'(0)};
            r_st[0].ovfy <= OW'(r3_magy) >= {SW'(r3_den), hpmbc_pkg::SHIFT_W'(0)};
            r_st[0].den  <= SW'(r3_den);
            r_st[0].remx <= r3_magx >> hpmbc_pkg::SHIFT_W;
            r_st[0].remy <= r3_magy >> hpmbc_pkg::SHIFT_W;
            r_st[0].lowx <= {r3_magx[hpmbc_pkg::SHIFT_W-1:0], hpmbc_pkg::FRAC_W'(0)};
            r_st[0].lowy <= {r3_magy[hpmbc_pkg::SHIFT_W-1:0], hpmbc_pkg::FRAC_W'(0)};
            r_st[0].qx   <= '0;
            r_st[0].qy   <= '0;
        end
    end

    // Divider stages: one restoring quotient bit per stage for x and y.
    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [SW:0]   tx, ty;
        logic [SW:0]   dd;
        logic          bx, by;
        hpmbc_pkg::t_div_stage n_st;

        assign dd = {1'b0, r_st[k].den};
        assign tx = {r_st[k].remx, r_st[k].lowx[QW-1]};
        assign ty = {r_st[k].remy, r_st[k].lowy[QW-1]};
        assign bx = tx >= dd;
        assign by = ty >= dd;

        // Next stage contents: pass everything along, step the division.
        always_comb begin
            n_st      = r_st[k];
            n_st.remx = SW'(bx ? tx - dd : tx);
            n_st.remy = SW'(by ? ty - dd : ty);
            n_st.lowx = {r_st[k].lowx[QW-2:0], 1'b0};
            n_st.lowy = {r_st[k].lowy[QW-2:0], 1'b0};
            n_st.qx   = {r_st[k].qx[QW-2:0], bx};
            n_st.qy   = {r_st[k].qy[QW-2:0], by};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // Output stage: sign, saturation and the non-positive denominator case.
    logic signed [hpmbc_pkg::OUT_W-1:0] s_x, s_y;
    logic signed [hpmbc_pkg::OUT_W-1:0] s_qx, s_qy;

    assign s_qx = $signed({1'b0, r_st[DS].qx});
    assign s_qy = $signed({1'b0, r_st[DS].qy});

    always_comb begin
        if (!r_st[DS].dpos) begin
            s_x = '0;
        end else if (r_st[DS].ovfx) begin
            s_x = r_st[DS].negx ? hpmbc_pkg::OUT_MIN : hpmbc_pkg::OUT_MAX;
        end else begin
            s_x = r_st[DS].negx ? -s_qx : s_qx;
        end
        if (!r_st[DS].dpos) begin
            s_y = '0;
        end else if (r_st[DS].ovfy) begin
            s_y = r_st[DS].negy ? hpmbc_pkg::OUT_MIN : hpmbc_pkg::OUT_MAX;
        end else begin
            s_y = r_st[DS].negy ? -s_qy : s_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_vld[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_req.echo_col <= r_st[DS].col;
            o_out_req.echo_row <= r_st[DS].row;
            o_out_req.source_x <= s_x;
            o_out_req.source_y <= s_y;
            o_out_req.outlier  <= r_st[DS].outl;
        end
    end

endmodule

`default_nettype wire
